// File: rtl/ppp_pkg.sv
// Shared types and constants for the perspective point projection block.
package ppp_pkg;

    // Configuration register map, in word order
    typedef enum logic [2:0] {
        REG_VIEW_X,
        REG_VIEW_Y,
        REG_VIEW_Z,
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_PLANE_OFFSET,
        REG_ALPHA_MARGIN
    } reg_idx_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MARGIN   = 2'd1,
        ST_ZERO_DEN = 2'd2
    } status_t;

    // Reset value of the factor margin (raw fixed-point bits)
    localparam int MARGIN_RESET = 66;

    // Per-beat side information carried along the divider and output stages
    typedef struct packed {
        logic       last;
        logic       zero_den;
        status_t    status;
        logic [2:0] neg;
        logic [2:0] ovf;
    } ppp_side_t;

endpackage

// File: rtl/perspective_point_projection.sv
// Top level: projects a stream of points from a view point onto a plane.
//
//  channel  dir   beat contents
//  s_axis   in    tdata: point_x, point_y, point_z; tlast: last_in_set
//  m_axis   out   tdata: image_x, image_y, image_z; tuser: status; tlast: last_out
//  apb      in    view_x/y/z, normal_x/y/z, plane_offset, alpha_margin
//
// One point enters every cycle while the pipe advances; the stages are nine
// front stages, one divider stage per quotient bit, two output stages.
// All stages advance together whenever the output register is empty or taken,
// so a stall freezes the whole pipe and no beat is lost or repeated.
// rst_n clears the valid bits and loads the register reset values.
module perspective_point_projection
    import ppp_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int W      = COORD_WIDTH,
    localparam int TDW    = ((3 * W + 7) / 8) * 8,
    localparam int APB_DW = (W > 32) ? 64 : 32,
    localparam int APB_AW = (W > 32) ? 6 : 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [TDW-1:0]    s_axis_tdata,   // point_x, point_y, point_z
    input  logic              s_axis_tlast,
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [TDW-1:0]    m_axis_tdata,   // image_x, image_y, image_z
    output logic [1:0]        m_axis_tuser,   // status
    output logic              m_axis_tlast,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SW  = ((W + FRAC_BITS > 2 * W) ? W + FRAC_BITS : 2 * W) + 3;
    localparam int NMW = SW - 1;
    localparam int MW  = NMW + W + 2;
    localparam int RW  = NMW + 1;
    localparam int QW  = W + 1;

    logic [W-1:0] view_x, view_y, view_z;
    logic [W-1:0] normal_x, normal_y, normal_z;
    logic [W-1:0] plane_offset;
    logic [W-2:0] alpha_margin;

    logic          adv;
    logic          fr_valid, dv_valid;
    logic [MW-1:0] fr_mag [3];
    logic [RW-1:0] fr_den2;
    ppp_side_t     fr_side, dv_side;
    logic [QW-1:0] dv_quo [3];
    logic [2:0]    dv_rem_nz;
    logic [W-1:0]  image_x, image_y, image_z;
    status_t       status;

    // whole pipe moves when the output register can take a beat
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign pready        = 1'b1;

    ppp_cfg #(
        .W  (W),
        .F  (FRAC_BITS),
        .AW (APB_AW),
        .DW (APB_DW)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .view_x       (view_x),
        .view_y       (view_y),
        .view_z       (view_z),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .alpha_margin (alpha_margin)
    );

    ppp_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (s_axis_tvalid),
        .point_x      (s_axis_tdata[W-1:0]),
        .point_y      (s_axis_tdata[2*W-1:W]),
        .point_z      (s_axis_tdata[3*W-1:2*W]),
        .in_last      (s_axis_tlast),
        .view_x       (view_x),
        .view_y       (view_y),
        .view_z       (view_z),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .alpha_margin (alpha_margin),
        .out_valid    (fr_valid),
        .mag          (fr_mag),
        .den2         (fr_den2),
        .side         (fr_side)
    );

    ppp_div #(
        .W (W),
        .F (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .mag       (fr_mag),
        .den2      (fr_den2),
        .in_side   (fr_side),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .rem_nz    (dv_rem_nz),
        .out_side  (dv_side)
    );

    ppp_out #(
        .W (W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dv_valid),
        .quo       (dv_quo),
        .rem_nz    (dv_rem_nz),
        .in_side   (dv_side),
        .view_x    (view_x),
        .view_y    (view_y),
        .view_z    (view_z),
        .out_valid (m_axis_tvalid),
        .image_x   (image_x),
        .image_y   (image_y),
        .image_z   (image_z),
        .status    (status),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = TDW'({image_z, image_y, image_x});
    assign m_axis_tuser = status;

endmodule

// File: rtl/ppp_cfg.sv
// APB register file holding view point, plane normal, plane offset and margin.
module ppp_cfg
    import ppp_pkg::*;
#(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int AW = 5,
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [DW-1:0] pwdata,
    output logic [DW-1:0] prdata,
    output logic [W-1:0]  view_x,
    output logic [W-1:0]  view_y,
    output logic [W-1:0]  view_z,
    output logic [W-1:0]  normal_x,
    output logic [W-1:0]  normal_y,
    output logic [W-1:0]  normal_z,
    output logic [W-1:0]  plane_offset,
    output logic [W-2:0]  alpha_margin
);

    logic [W-1:0] view_x_reg, view_y_reg, view_z_reg;
    logic [W-1:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic [W-1:0] plane_offset_reg;
    logic [W-2:0] alpha_margin_reg;
    reg_idx_t     idx;
    logic         wr_en;

    assign idx   = reg_idx_t'(paddr[AW-1 -: 3]);
    assign wr_en = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_x_reg       <= '0;
            view_y_reg       <= '0;
            view_z_reg       <= '0;
            normal_x_reg     <= '0;
            normal_y_reg     <= '0;
            normal_z_reg     <= W'(1) << F;
            plane_offset_reg <= '0;
            alpha_margin_reg <= (W-1)'(MARGIN_RESET);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_VIEW_X:       view_x_reg       <= pwdata[W-1:0];
                REG_VIEW_Y:       view_y_reg       <= pwdata[W-1:0];
                REG_VIEW_Z:       view_z_reg       <= pwdata[W-1:0];
                REG_NORMAL_X:     normal_x_reg     <= pwdata[W-1:0];
                REG_NORMAL_Y:     normal_y_reg     <= pwdata[W-1:0];
                REG_NORMAL_Z:     normal_z_reg     <= pwdata[W-1:0];
                REG_PLANE_OFFSET: plane_offset_reg <= pwdata[W-1:0];
                REG_ALPHA_MARGIN: alpha_margin_reg <= pwdata[W-2:0];
                default:          ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_VIEW_X:       prdata = DW'(view_x_reg);
            REG_VIEW_Y:       prdata = DW'(view_y_reg);
            REG_VIEW_Z:       prdata = DW'(view_z_reg);
            REG_NORMAL_X:     prdata = DW'(normal_x_reg);
            REG_NORMAL_Y:     prdata = DW'(normal_y_reg);
            REG_NORMAL_Z:     prdata = DW'(normal_z_reg);
            REG_PLANE_OFFSET: prdata = DW'(plane_offset_reg);
            REG_ALPHA_MARGIN: prdata = DW'(alpha_margin_reg);
            default:          prdata = '0;
        endcase
    end

    assign view_x       = view_x_reg;
    assign view_y       = view_y_reg;
    assign view_z       = view_z_reg;
    assign normal_x     = normal_x_reg;
    assign normal_y     = normal_y_reg;
    assign normal_z     = normal_z_reg;
    assign plane_offset = plane_offset_reg;
    assign alpha_margin = alpha_margin_reg;

endmodule

// File: rtl/ppp_front.sv
// Nine-stage front end: dot products, sign handling, split products, dividend.
module ppp_front
    import ppp_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16,
    localparam int SW  = ((W + F > 2 * W) ? W + F : 2 * W) + 3,
    localparam int NMW = SW - 1,
    localparam int DW  = W + 1,
    localparam int PMW = NMW + DW,
    localparam int TW  = PMW + 2,
    localparam int MW  = TW - 1,
    localparam int RW  = NMW + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [W-1:0]  point_x,
    input  logic [W-1:0]  point_y,
    input  logic [W-1:0]  point_z,
    input  logic          in_last,
    input  logic [W-1:0]  view_x,
    input  logic [W-1:0]  view_y,
    input  logic [W-1:0]  view_z,
    input  logic [W-1:0]  normal_x,
    input  logic [W-1:0]  normal_y,
    input  logic [W-1:0]  normal_z,
    input  logic [W-1:0]  plane_offset,
    input  logic [W-2:0]  alpha_margin,
    output logic          out_valid,
    output logic [MW-1:0] mag [3],
    output logic [RW-1:0] den2,
    output ppp_side_t     side
);

    localparam int NS  = 9;
    localparam int PW  = 2 * W + 1;
    localparam int NVW = 2 * W;
    localparam int LO  = (NMW + 1) / 2;
    localparam int HI  = NMW - LO;
    localparam int PLW = LO + DW;
    localparam int PHW = HI + DW;
    localparam int MLW = W - 1 + LO;
    localparam int MHW = W - 1 + HI;
    localparam int RHW = NMW + W - 1;
    localparam int CMW = NMW + F + W;
    localparam int QW  = W + 1;

    logic signed [W-1:0] pt [3];
    logic signed [W-1:0] vw [3];
    logic signed [W-1:0] nrm [3];

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] last_reg;

    // stage payloads
    logic signed [DW-1:0]  s1_d_reg [3];
    logic signed [DW-1:0]  s2_d_reg [3];
    logic signed [PW-1:0]  s2_nd_reg [3];
    logic signed [NVW-1:0] s2_nv_reg [3];
    logic signed [DW-1:0]  s3_d_reg [3];
    logic signed [SW-1:0]  s3_den_reg, s3_num_reg;
    logic [DW-1:0]         s4_dmag_reg [3];
    logic [2:0]            s4_dneg_reg;
    logic [NMW-1:0]        s4_num_mag_reg, s4_den_mag_reg;
    logic                  s4_num_neg_reg;
    logic [5:0]            zero_reg;
    logic [PLW-1:0]        s5_pl_reg [3];
    logic [PHW-1:0]        s5_ph_reg [3];
    logic [MLW-1:0]        s5_ml_reg;
    logic [MHW-1:0]        s5_mh_reg;
    logic [2:0]            s5_psign_reg;
    logic [NMW-1:0]        s5_num_mag_reg, s5_den_mag_reg;
    logic                  s5_num_neg_reg;
    logic [PMW-1:0]        s6_pm_reg [3];
    logic [RHW-1:0]        s6_rhs_reg;
    logic [2:0]            s6_psign_reg;
    logic [NMW-1:0]        s6_num_mag_reg, s6_den_mag_reg;
    logic                  s6_num_neg_reg;
    logic [TW-1:0]         s7_top_reg [3];
    logic [NMW-1:0]        s7_den_mag_reg;
    status_t               s7_status_reg, s8_status_reg, s9_status_reg;
    logic [MW-1:0]         s8_mag_reg [3];
    logic [RW-1:0]         s8_den2_reg;
    logic [2:0]            s8_neg_reg;
    logic [MW-1:0]         s9_mag_reg [3];
    logic [RW-1:0]         s9_den2_reg;
    logic [2:0]            s9_neg_reg, s9_ovf_reg;

    // combinational helpers
    logic signed [SW-1:0]  den_abs, num_abs;
    logic                  den_neg;
    logic                  margin_ok;
    logic [TW-1:0]         top_abs [3];

    always_comb
    begin
        pt[0]  = $signed(point_x);
        pt[1]  = $signed(point_y);
        pt[2]  = $signed(point_z);
        vw[0]  = $signed(view_x);
        vw[1]  = $signed(view_y);
        vw[2]  = $signed(view_z);
        nrm[0] = $signed(normal_x);
        nrm[1] = $signed(normal_y);
        nrm[2] = $signed(normal_z);
    end

    // sign normalization of the denominator
    always_comb
    begin
        den_neg = s3_den_reg[SW-1];
        den_abs = den_neg ? -s3_den_reg : s3_den_reg;
        num_abs = s3_num_reg[SW-1] ? -s3_num_reg : s3_num_reg;
    end

    // margin test: status ok when num * 2^F > margin * den
    assign margin_ok = !s6_num_neg_reg &&
                       ((CMW'(s6_num_mag_reg) << F) > CMW'(s6_rhs_reg));

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            top_abs[c] = s7_top_reg[c][TW-1] ? -s7_top_reg[c] : s7_top_reg[c];
        end
    end

    // valid and last travel with the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= {last_reg[NS-2:0], in_last};
            // zero flag enters at stage 4 and rides to stage 9
            zero_reg <= {zero_reg[4:0], (s3_den_reg == '0)};

            // stage 1: delta from view point
            for (int c = 0; c < 3; c++)
            begin
                s1_d_reg[c] <= DW'(pt[c]) - DW'(vw[c]);
            end

            // stage 2: normal products
            for (int c = 0; c < 3; c++)
            begin
                s2_d_reg[c]  <= s1_d_reg[c];
                s2_nd_reg[c] <= PW'(nrm[c]) * PW'(s1_d_reg[c]);
                s2_nv_reg[c] <= NVW'(nrm[c]) * NVW'(vw[c]);
            end

            // stage 3: denominator and numerator sums
            s3_d_reg   <= s2_d_reg;
            s3_den_reg <= SW'(s2_nd_reg[0]) + SW'(s2_nd_reg[1]) + SW'(s2_nd_reg[2]);
            s3_num_reg <= (SW'($signed(plane_offset)) <<< F) - SW'(s2_nv_reg[0])
                          - SW'(s2_nv_reg[1]) - SW'(s2_nv_reg[2]);

            // stage 4: magnitudes, denominator made positive
            s4_den_mag_reg <= NMW'(den_abs);
            s4_num_mag_reg <= NMW'(num_abs);
            s4_num_neg_reg <= s3_num_reg[SW-1] ^ den_neg;
            for (int c = 0; c < 3; c++)
            begin
                s4_dneg_reg[c] <= s3_d_reg[c][DW-1];
                s4_dmag_reg[c] <= s3_d_reg[c][DW-1] ? DW'(-s3_d_reg[c]) : DW'(s3_d_reg[c]);
            end

            // stage 5: partial products
            for (int c = 0; c < 3; c++)
            begin
                s5_pl_reg[c] <= PLW'(s4_num_mag_reg[LO-1:0]) * PLW'(s4_dmag_reg[c]);
                s5_ph_reg[c] <= PHW'(s4_num_mag_reg[NMW-1:LO]) * PHW'(s4_dmag_reg[c]);
            end
            s5_ml_reg      <= MLW'(alpha_margin) * MLW'(s4_den_mag_reg[LO-1:0]);
            s5_mh_reg      <= MHW'(alpha_margin) * MHW'(s4_den_mag_reg[NMW-1:LO]);
            s5_psign_reg   <= s4_dneg_reg ^ {3{s4_num_neg_reg}};
            s5_num_mag_reg <= s4_num_mag_reg;
            s5_den_mag_reg <= s4_den_mag_reg;
            s5_num_neg_reg <= s4_num_neg_reg;

            // stage 6: combine partial products
            for (int c = 0; c < 3; c++)
            begin
                s6_pm_reg[c] <= PMW'(s5_pl_reg[c]) + (PMW'(s5_ph_reg[c]) << LO);
            end
            s6_rhs_reg     <= RHW'(s5_ml_reg) + (RHW'(s5_mh_reg) << LO);
            s6_psign_reg   <= s5_psign_reg;
            s6_num_mag_reg <= s5_num_mag_reg;
            s6_den_mag_reg <= s5_den_mag_reg;
            s6_num_neg_reg <= s5_num_neg_reg;

            // stage 7: dividend 2*num*d + den, margin status
            for (int c = 0; c < 3; c++)
            begin
                s7_top_reg[c] <= s6_psign_reg[c]
                               ? TW'(s6_den_mag_reg) - (TW'(s6_pm_reg[c]) << 1)
                               : TW'(s6_den_mag_reg) + (TW'(s6_pm_reg[c]) << 1);
            end
            s7_den_mag_reg <= s6_den_mag_reg;
            s7_status_reg  <= margin_ok ? ST_OK : ST_MARGIN;

            // stage 8: dividend magnitude, divisor 2*den
            for (int c = 0; c < 3; c++)
            begin
                s8_neg_reg[c] <= s7_top_reg[c][TW-1];
                s8_mag_reg[c] <= MW'(top_abs[c]);
            end
            s8_den2_reg   <= {s7_den_mag_reg, 1'b0};
            s8_status_reg <= s7_status_reg;

            // stage 9: quotient overflow check
            for (int c = 0; c < 3; c++)
            begin
                s9_ovf_reg[c] <= s8_mag_reg[c] >= {s8_den2_reg, {QW{1'b0}}};
            end
            s9_mag_reg    <= s8_mag_reg;
            s9_den2_reg   <= s8_den2_reg;
            s9_neg_reg    <= s8_neg_reg;
            s9_status_reg <= s8_status_reg;
        end
    end

    assign out_valid     = valid_reg[NS-1];
    assign mag           = s9_mag_reg;
    assign den2          = s9_den2_reg;
    assign side.last     = last_reg[NS-1];
    assign side.zero_den = zero_reg[5];
    assign side.status   = s9_status_reg;
    assign side.neg      = s9_neg_reg;
    assign side.ovf      = s9_ovf_reg;

endmodule

// File: rtl/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage for three lanes.
module ppp_div
    import ppp_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16,
    localparam int SW  = ((W + F > 2 * W) ? W + F : 2 * W) + 3,
    localparam int NMW = SW - 1,
    localparam int MW  = NMW + W + 2,
    localparam int RW  = NMW + 1,
    localparam int QW  = W + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [MW-1:0] mag [3],
    input  logic [RW-1:0] den2,
    input  ppp_side_t     in_side,
    output logic          out_valid,
    output logic [QW-1:0] quo [3],
    output logic [2:0]    rem_nz,
    output ppp_side_t     out_side
);

    logic [RW-1:0] r_reg   [QW][3];
    logic [QW-1:0] low_reg [QW][3];
    logic [QW-1:0] q_reg   [QW][3];
    logic [RW-1:0] den_reg [QW];
    ppp_side_t     side_reg [QW];
    logic [QW-1:0] valid_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [RW-1:0] den_in;
        ppp_side_t     side_in;
        logic          v_in;

        if (i == 0)
        begin : g_first
            assign den_in  = den2;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign den_in  = den_reg[i-1];
            assign side_in = side_reg[i-1];
            assign v_in    = valid_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in;
            end
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_lane
            logic [RW-1:0] r_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] q_in;
            logic [RW:0]   r_sh;
            logic          ge;

            if (i == 0)
            begin : g_first
                assign r_in   = mag[c][MW-1:QW];
                assign low_in = mag[c][QW-1:0];
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign r_in   = r_reg[i-1][c];
                assign low_in = low_reg[i-1][c];
                assign q_in   = q_reg[i-1][c];
            end

            // shift in next dividend bit, trial subtract
            assign r_sh = {r_in, low_in[QW-1]};
            assign ge   = r_sh >= {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_reg[i][c]   <= ge ? RW'(r_sh - {1'b0, den_in}) : RW'(r_sh);
                    low_reg[i][c] <= low_in << 1;
                    q_reg[i][c]   <= {q_in[QW-2:0], ge};
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_side  = side_reg[QW-1];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            quo[c]    = q_reg[QW-1][c];
            rem_nz[c] = r_reg[QW-1][c] != '0;
        end
    end

endmodule

// File: rtl/ppp_out.sv
// Floor correction, view offset, saturation and the output register.
module ppp_out
    import ppp_pkg::*;
#(
    parameter int W = 32,
    localparam int QW = W + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [QW-1:0] quo [3],
    input  logic [2:0]    rem_nz,
    input  ppp_side_t     in_side,
    input  logic [W-1:0]  view_x,
    input  logic [W-1:0]  view_y,
    input  logic [W-1:0]  view_z,
    output logic          out_valid,
    output logic [W-1:0]  image_x,
    output logic [W-1:0]  image_y,
    output logic [W-1:0]  image_z,
    output status_t       status,
    output logic          last
);

    localparam int QSW = W + 3;
    localparam logic signed [QSW-1:0] SAT_HI = (QSW'(1) << (W - 1)) - QSW'(1);
    localparam logic signed [QSW-1:0] SAT_LO = -(QSW'(1) << (W - 1));

    logic signed [QSW-1:0] qs_reg [3];
    ppp_side_t             side_reg;
    logic                  valid_reg, out_valid_reg;
    logic [W-1:0]          img_reg [3];
    status_t               status_reg;
    logic                  last_reg;

    logic signed [W-1:0]   vw [3];
    logic signed [QSW-1:0] sum [3];
    logic [W-1:0]          img_next [3];

    always_comb
    begin
        vw[0] = $signed(view_x);
        vw[1] = $signed(view_y);
        vw[2] = $signed(view_z);
    end

    // add view point, clamp to coordinate range; a zero denominator gives the view point
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = QSW'(vw[c]) + qs_reg[c];
            if (side_reg.zero_den)
                img_next[c] = W'(vw[c]);
            else if (side_reg.ovf[c])
                img_next[c] = side_reg.neg[c] ? W'(SAT_LO) : W'(SAT_HI);
            else if (sum[c] > SAT_HI)
                img_next[c] = W'(SAT_HI);
            else if (sum[c] < SAT_LO)
                img_next[c] = W'(SAT_LO);
            else
                img_next[c] = W'(sum[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= in_valid;
            out_valid_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // signed floor quotient: negative side rounds away on remainder
            for (int c = 0; c < 3; c++)
            begin
                qs_reg[c] <= in_side.neg[c]
                           ? -($signed(QSW'(quo[c])) + $signed(QSW'(rem_nz[c])))
                           : $signed(QSW'(quo[c]));
            end
            side_reg <= in_side;

            img_reg    <= img_next;
            status_reg <= side_reg.zero_den ? ST_ZERO_DEN : side_reg.status;
            last_reg   <= side_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign image_x   = img_reg[0];
    assign image_y   = img_reg[1];
    assign image_z   = img_reg[2];
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// File: sim/tb.sv
// Testbench for perspective_point_projection: random and directed points checked against a predictor.
module tb;
    import ppp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    localparam int FB = 16;
    localparam int LATENCY = W + 12;

    typedef struct {
        logic signed [W-1:0] ix;
        logic signed [W-1:0] iy;
        logic signed [W-1:0] iz;
        status_t             st;
        logic                last;
    } image_t;

    // Projection predictor and store of pending images
    class projection_board;
        logic signed [W-1:0] view [3];
        logic signed [W-1:0] nrm [3];
        logic signed [W-1:0] offset;
        logic [W-2:0]        margin;
        image_t              pending [$];
        int                  errors;

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_VIEW_X:       view[0] = val;
                REG_VIEW_Y:       view[1] = val;
                REG_VIEW_Z:       view[2] = val;
                REG_NORMAL_X:     nrm[0] = val;
                REG_NORMAL_Y:     nrm[1] = val;
                REG_NORMAL_Z:     nrm[2] = val;
                REG_PLANE_OFFSET: offset = val;
                default:          margin = val[W-2:0];
            endcase
        endfunction

        // floor(a / b), b > 0
        function logic signed [191:0] floor_div(logic signed [191:0] a, logic signed [191:0] b);
            logic signed [191:0] q;
            q = a / b;
            if (a % b != 0 && a < 0)
                q = q - 1;
            return q;
        endfunction

        function void note_point(logic signed [W-1:0] p [3], logic last);
            logic signed [191:0] d [3];
            logic signed [191:0] den, num, top, r, hi, lo;
            image_t e;
            hi = (192'sd1 <<< (W - 1)) - 1;
            lo = -hi - 1;
            den = 0;
            num = 192'(signed'(offset)) <<< FB;
            for (int c = 0; c < 3; c++)
            begin
                d[c] = 192'(signed'(p[c])) - 192'(signed'(view[c]));
                den = den + 192'(signed'(nrm[c])) * d[c];
                num = num - 192'(signed'(nrm[c])) * 192'(signed'(view[c]));
            end
            e.last = last;
            if (den == 0)
            begin
                e.ix = view[0];
                e.iy = view[1];
                e.iz = view[2];
                e.st = ST_ZERO_DEN;
            end
            else
            begin
                if (den < 0)
                begin
                    den = -den;
                    num = -num;
                end
                e.st = ((num <<< FB) > 192'(signed'({1'b0, margin})) * den) ? ST_OK : ST_MARGIN;
                for (int c = 0; c < 3; c++)
                begin
                    top = 2 * num * d[c] + den;
                    r = 192'(signed'(view[c])) + floor_div(top, 2 * den);
                    if (r > hi)
                        r = hi;
                    else if (r < lo)
                        r = lo;
                    if (c == 0) e.ix = r[W-1:0];
                    else if (c == 1) e.iy = r[W-1:0];
                    else e.iz = r[W-1:0];
                end
            end
            pending.push_back(e);
        endfunction

        function void check_image(image_t a);
            image_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat x=%h y=%h z=%h", $time, a.ix, a.iy, a.iz);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.ix !== e.ix || a.iy !== e.iy || a.iz !== e.iz)
            begin
                $display("%0t: image exp %h %h %h got %h %h %h", $time,
                         e.ix, e.iy, e.iz, a.ix, a.iy, a.iz);
                errors++;
            end
            if (a.st !== e.st)
            begin
                $display("%0t: status exp %0d got %0d", $time, e.st, a.st);
                errors++;
            end
            if (a.last !== e.last)
            begin
                $display("%0t: last exp %b got %b", $time, e.last, a.last);
                errors++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [95:0]     s_axis_tdata;   // point_x, point_y, point_z
    logic            s_axis_tlast;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [95:0]     m_axis_tdata;   // image_x, image_y, image_z
    logic [1:0]      m_axis_tuser;   // status
    logic            m_axis_tlast;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [4:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    projection_board board;
    int              hold_off;
    bit              in_done;

    perspective_point_projection u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 200) - 100;
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Register write: setup then access
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 5'(idx) << 2;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        logic signed [W-1:0] p [3];
        repeat (gap_len()) @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {z, y, x};
        s_axis_tlast = last;
        do @(posedge clk); while (!s_axis_tready);
        p[0] = x;
        p[1] = y;
        p[2] = z;
        board.note_point(p, last);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Receiver with random stalls and one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_axis_tready = 1'b0;
                hold_off--;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) < 70) || in_done;
        end
    end

    always @(posedge clk)
    begin
        image_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.ix = m_axis_tdata[31:0];
            a.iy = m_axis_tdata[63:32];
            a.iz = m_axis_tdata[95:64];
            a.st = status_t'(m_axis_tuser);
            a.last = m_axis_tlast;
            board.check_image(a);
        end
    end

    // Settings per phase: view, normal, offset, margin
    task automatic random_setup(int kind);
        for (int i = 0; i < 8; i++)
        begin
            logic [31:0] v;
            case (kind)
                0: v = (i == 5) ? 32'h0001_0000 : 32'd0;
                1: v = (i == 7) ? 32'h7fff_ffff : 32'h8000_0000;
                2: v = (i == 7) ? 32'd0 : 32'h7fff_ffff;
                default: v = (i == 7) ? 32'($urandom_range(0, 200000)) : rnd_coord();
            endcase
            write_reg(reg_idx_t'(i), v);
        end
    endtask

    initial
    begin
        board = new();
        board.view = '{0, 0, 0};
        board.nrm = '{0, 0, 32'h0001_0000};
        board.offset = 0;
        board.margin = 66;
        board.errors = 0;
        hold_off = 0;
        in_done = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, zero denominator, extremes
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 1'b1);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
        drain();
        write_reg(REG_PLANE_OFFSET, 32'h0001_0000);
        write_reg(REG_VIEW_Z, 32'hfff0_0000);
        send_point(32'h0004_0000, 32'hfffc_0000, 32'h0002_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'hfff0_0001, 1'b0);
        send_point(32'h1234_5678, 32'h8000_0000, 32'hfff0_0000, 1'b1);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 1'b0);
        drain();
        for (int k = 1; k <= 3; k++)
        begin
            random_setup(k);
            for (int j = 0; j < 5; j++)
                send_point(rnd_coord(), rnd_coord(), rnd_coord(), $urandom_range(0, 1));
            drain();
        end

        // Random phases, with a long receiver hold-off in the first
        for (int ph = 0; ph < 6; ph++)
        begin
            random_setup(ph == 5 ? 0 : 3);
            if (ph == 0)
                hold_off = 300;
            for (int j = 0; j < 100; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_point(board.view[0], board.view[1], board.view[2], 1'b0);
                else
                    send_point(rnd_coord(), rnd_coord(), rnd_coord(), $urandom_range(0, 1));
            end
            drain();
        end
        in_done = 1;
        drain();
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: perspective_point_projection.f
rtl/ppp_pkg.sv
rtl/ppp_cfg.sv
rtl/ppp_front.sv
rtl/ppp_div.sv
rtl/ppp_out.sv
rtl/perspective_point_projection.sv
sim/tb.sv
